// ===== design/input_binding_latch_top_macros.svh =====
// Assertion macros shared by the input binding latch RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef INPUT_BINDING_LATCH_TOP_MACROS_SVH
`define INPUT_BINDING_LATCH_TOP_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset
`define IBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("input binding latch check failed");

// Next-cycle implication under a synchronous active-low reset
`define IBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("input binding latch check failed");

`endif

// ===== design/ibl_pkg.sv =====
// Shared types, codes and helpers for the input binding latch.
// No dependencies; imported by the scan engine and the top level.
`timescale 1ns / 1ps
package ibl_pkg;

    localparam int ACTIONS     = 16;
    localparam int PAD_BUTTONS = 32;
    localparam int SLOTS       = 4;
    localparam int ENTRIES     = ACTIONS * SLOTS;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int ACT_W       = $clog2(ACTIONS);
    localparam int CODE_W      = 9;

    // input modes
    localparam logic [2:0] MODE_KEY_DOWN   = 3'd0;
    localparam logic [2:0] MODE_KEY_UP     = 3'd1;
    localparam logic [2:0] MODE_MOUSE_DOWN = 3'd2;
    localparam logic [2:0] MODE_MOUSE_UP   = 3'd3;
    localparam logic [2:0] MODE_WHEEL      = 3'd4;
    localparam logic [2:0] MODE_FRAME      = 3'd5;
    localparam logic [2:0] MODE_BIND       = 3'd6;

    // internal operations after decode
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_KEY_DN   = 3'd1;
    localparam logic [2:0] OP_KEY_UP   = 3'd2;
    localparam logic [2:0] OP_MOUSE_DN = 3'd3;
    localparam logic [2:0] OP_MOUSE_UP = 3'd4;
    localparam logic [2:0] OP_WHEEL    = 3'd5;
    localparam logic [2:0] OP_FRAME    = 3'd6;
    localparam logic [2:0] OP_BIND     = 3'd7;

    // slot kinds within an action
    localparam logic [1:0] SLOT_KEY   = 2'd0;
    localparam logic [1:0] SLOT_ALT   = 2'd1;
    localparam logic [1:0] SLOT_MOUSE = 2'd2;
    localparam logic [1:0] SLOT_PAD   = 2'd3;

    // latch codes
    localparam logic [1:0] LATCH_OFF  = 2'd0;
    localparam logic [1:0] LATCH_JUST = 2'd1;
    localparam logic [1:0] LATCH_HELD = 2'd2;
    localparam logic [1:0] LATCH_ONCE = 2'd3;

    localparam logic [CODE_W-1:0] WHEEL_UP_CODE   = 9'h1FF;
    localparam logic [CODE_W-1:0] WHEEL_DOWN_CODE = 9'h1FE;

    // config register indexes
    localparam logic [0:0] REG_PAD_PRESENT = 1'd0;

    typedef struct packed {
        logic [2:0]        mode;
        logic [CODE_W-1:0] code;
        logic              key_repeat;
        logic signed [1:0] wheel_step;
        logic [31:0]       pad_buttons;
        logic [3:0]        bind_index;
        logic [1:0]        bind_slot;
        logic              bind_oneshot;
    } t_cmd;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [1:0]        latch;
    } t_entry;

    // Age a latch at the end of a frame
    function automatic logic [1:0] age_latch(input logic [1:0] l);
        logic [1:0] r;
        case (l)
            LATCH_ONCE: r = LATCH_OFF;
            LATCH_JUST: r = LATCH_HELD;
            default:    r = l;
        endcase
        return r;
    endfunction

    // Decode an input beat into an internal operation
    function automatic logic [2:0] decode_op(input t_cmd c);
        logic [2:0] op;
        op = OP_NONE;
        case (c.mode)
            MODE_KEY_DOWN:   if (!c.key_repeat && c.code != '0) op = OP_KEY_DN;
            MODE_KEY_UP:     if (c.code != '0) op = OP_KEY_UP;
            MODE_MOUSE_DOWN: if (c.code != '0) op = OP_MOUSE_DN;
            MODE_MOUSE_UP:   if (c.code != '0) op = OP_MOUSE_UP;
            MODE_WHEEL:      if (c.wheel_step != 2'sd0) op = OP_WHEEL;
            MODE_FRAME:      op = OP_FRAME;
            MODE_BIND:       if ({1'b0, c.bind_index} < ACTIONS) op = OP_BIND;
            default:         op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ===== design/ibl_engine.sv =====
// Slot memory and sequential scan engine of the input binding latch.
// Depends on ibl_pkg and input_binding_latch_top_macros.svh.
`timescale 1ns / 1ps
`include "input_binding_latch_top_macros.svh"
module ibl_engine
    import ibl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cmd               i_cmd,
    input  logic               i_pad_present,
    input  logic               i_out_free,
    output logic               o_busy,
    output logic               o_done,
    output logic [ACTIONS-1:0] o_en,
    output logic [ACTIONS-1:0] o_os
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    t_entry mem [ENTRIES];
    t_entry r_rdata;

    logic [1:0]         r_state;
    logic [2:0]         r_op;
    logic [CODE_W-1:0]  r_code;
    logic [31:0]        r_buttons;
    logic [ADDR_W-1:0]  r_raddr;
    logic               r_issue;
    logic               r_pv;
    logic [ADDR_W-1:0]  r_paddr;
    logic               r_rvalid;
    logic               r_found;
    logic [ENTRIES-1:0] r_valid;
    logic [ACTIONS-1:0] r_oneshot;
    logic [ACTIONS-1:0] r_en;
    logic [ACTIONS-1:0] r_os;

    logic [2:0]         start_op;
    logic [ADDR_W-1:0]  bind_addr;
    logic [1:0]         slot;
    logic [ACT_W-1:0]   act;
    logic [CODE_W-1:0]  cur_code;
    logic [1:0]         cur_latch;
    logic [1:0]         pad_latch;
    logic [1:0]         new_latch;
    logic               slot_ok;
    logic               match;
    logic               pressed;
    logic               hit;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    logic               last;

    assign start_op  = decode_op(i_cmd);
    assign bind_addr = {i_cmd.bind_index[ACT_W-1:0], i_cmd.bind_slot};

    // Pull apart the entry in the process stage
    assign slot      = r_paddr[1:0];
    assign act       = r_paddr[ADDR_W-1:2];
    assign cur_code  = r_rvalid ? r_rdata.code  : '0;
    assign cur_latch = r_rvalid ? r_rdata.latch : LATCH_OFF;
    assign last      = r_pv && (r_paddr == ADDR_W'(ENTRIES - 1));

    // Modify one entry: event edge or frame sample, report and age
    always_comb begin
        slot_ok   = 1'b0;
        match     = 1'b0;
        pressed   = 1'b0;
        pad_latch = cur_latch;
        hit       = 1'b0;
        new_latch = cur_latch;
        case (r_op)
            OP_KEY_DN, OP_KEY_UP:
                slot_ok = (slot == SLOT_KEY) || (slot == SLOT_ALT);
            OP_MOUSE_DN, OP_MOUSE_UP, OP_WHEEL:
                slot_ok = (slot == SLOT_MOUSE);
            default:
                slot_ok = 1'b0;
        endcase
        match = r_pv && !r_found && slot_ok && (cur_code == r_code);
        case (r_op)
            OP_KEY_DN, OP_MOUSE_DN:
                new_latch = LATCH_JUST;
            OP_KEY_UP, OP_MOUSE_UP:
                new_latch = (cur_latch == LATCH_JUST) ? LATCH_ONCE : LATCH_OFF;
            OP_WHEEL:
                new_latch = LATCH_ONCE;
            OP_FRAME: begin
                if (i_pad_present && slot == SLOT_PAD) begin
                    pressed = (cur_code != '0) && (cur_code < CODE_W'(PAD_BUTTONS))
                              && r_buttons[cur_code[4:0]];
                    if (pressed) begin
                        pad_latch = (cur_latch == LATCH_OFF) ? LATCH_JUST : LATCH_HELD;
                    end else begin
                        pad_latch = LATCH_OFF;
                    end
                end
                if (r_oneshot[act]) begin
                    hit = (pad_latch == LATCH_JUST) || (pad_latch == LATCH_ONCE);
                end else begin
                    hit = (pad_latch != LATCH_OFF);
                end
                new_latch = age_latch(pad_latch);
            end
            default:
                new_latch = cur_latch;
        endcase
    end

    // Choose the memory write: bind in idle, else write back from the scan
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_paddr;
        mem_wdata = '{code: cur_code, latch: new_latch};
        if (i_start && start_op == OP_BIND) begin
            mem_we    = 1'b1;
            mem_waddr = bind_addr;
            mem_wdata = '{code: i_cmd.code, latch: LATCH_OFF};
        end else if (r_pv) begin
            mem_we = (r_op == OP_FRAME) || match;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (r_issue) begin
            r_rdata <= mem[r_raddr];
        end
    end

    // Scan sequencer, valid bits and mask accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_NONE;
            r_issue   <= 1'b0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= '0;
            r_oneshot <= '0;
            r_en      <= '0;
            r_os      <= '0;
        end else begin
            r_pv <= r_issue;
            if (r_issue) begin
                r_paddr  <= r_raddr;
                r_rvalid <= r_valid[r_raddr];
                r_raddr  <= r_raddr + 1'b1;
                if (r_raddr == ADDR_W'(ENTRIES - 1)) begin
                    r_issue <= 1'b0;
                end
            end
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (match) begin
                r_found <= 1'b1;
            end
            // record hits only from entries that are in the process stage
            if (r_pv && hit) begin
                r_en[act] <= 1'b1;
                if (r_oneshot[act]) begin
                    r_os[act] <= 1'b1;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        if (start_op == OP_BIND) begin
                            r_oneshot[i_cmd.bind_index[ACT_W-1:0]] <= i_cmd.bind_oneshot;
                        end else if (start_op != OP_NONE) begin
                            r_state   <= ST_SCAN;
                            r_op      <= start_op;
                            if (start_op == OP_WHEEL) begin
                                r_code <= (i_cmd.wheel_step == 2'sd1) ? WHEEL_UP_CODE
                                                                      : WHEEL_DOWN_CODE;
                            end else begin
                                r_code <= i_cmd.code;
                            end
                            r_buttons <= i_cmd.pad_buttons;
                            r_raddr   <= '0;
                            r_issue   <= 1'b1;
                            r_found   <= 1'b0;
                            r_en      <= '0;
                            r_os      <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (last) begin
                        r_state <= (r_op == OP_FRAME) ? ST_WAIT : ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_WAIT) && i_out_free;
    assign o_en   = r_en;
    assign o_os   = r_os;

    `IBL_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE)
    `IBL_ASSERT_IMP(a_one_match, i_clk, i_rst_n, mem_we && r_pv && r_op != OP_FRAME, !r_found)
    `IBL_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, r_state == ST_IDLE)
    `IBL_ASSERT_IMP(a_no_read_idle, i_clk, i_rst_n, r_state == ST_IDLE, !r_issue && !r_pv)

endmodule

// ===== design/input_binding_latch_top.sv =====
// Top level of the input binding latch: stream ports, config port, result register.
// Depends on ibl_pkg and ibl_engine.
//
// Use: each input beat on the s_axis channel carries one event selected by
// s_axis_tuser (key down/up, mouse down/up, wheel, frame tick, bind write).
// Only a frame tick produces a result beat on m_axis: the enabled-action mask
// and the one-shot mask. Bind writes and dropped events need no scan.
// Key, mouse, wheel and frame beats walk all 64 slot entries through a
// slot memory with one read and one write port, one entry per cycle; a
// frame tick then waits until the output register is free and loads its
// result into that register.
// The input takes a new beat as soon as the scan is done, while a finished
// result may still wait in the output register. If the receiver stalls and
// the register is still full when the next frame finishes, the engine holds
// that result and takes no input until the register frees up.
// Reset (synchronous, active low) marks every slot unbound and off, all
// actions held type, and pad_present cleared; no clearing pass is needed.
// Register pad_present lies at byte address 0 of the APB-style port.
`timescale 1ns / 1ps
module input_binding_latch_top
    import ibl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // code[8:0], key_repeat[9], wheel_step[11:10], pad_buttons[43:12],
    // bind_index[47:44], bind_slot[49:48], bind_oneshot[50], zero fill
    input  logic [55:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // enabled_mask[15:0], oneshot_mask[31:16]
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd               cmd;
    logic               eng_busy;
    logic               eng_done;
    logic [ACTIONS-1:0] eng_en;
    logic [ACTIONS-1:0] eng_os;
    logic               in_beat;
    logic               out_free;
    logic               r_pad_present;
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    // Unpack the input beat
    assign cmd.mode         = s_axis_tuser;
    assign cmd.code         = s_axis_tdata[8:0];
    assign cmd.key_repeat   = s_axis_tdata[9];
    assign cmd.wheel_step   = s_axis_tdata[11:10];
    assign cmd.pad_buttons  = s_axis_tdata[43:12];
    assign cmd.bind_index   = s_axis_tdata[47:44];
    assign cmd.bind_slot    = s_axis_tdata[49:48];
    assign cmd.bind_oneshot = s_axis_tdata[50];

    assign s_axis_tready = !eng_busy;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    ibl_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_beat),
        .i_cmd         (cmd),
        .i_pad_present (r_pad_present),
        .i_out_free    (out_free),
        .o_busy        (eng_busy),
        .o_done        (eng_done),
        .o_en          (eng_en),
        .o_os          (eng_os)
    );

    // Config register write
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_present <= 1'b0;
        end else if (psel && penable && pwrite && paddr == {REG_PAD_PRESENT, 2'b00}) begin
            r_pad_present <= pwdata[0];
        end
    end

    // Config register read
    always_comb begin
        prdata = '0;
        if (paddr == {REG_PAD_PRESENT, 2'b00}) begin
            prdata = {31'd0, r_pad_present};
        end
    end

    // Hold the result beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out_data <= {16'(eng_os), 16'(eng_en)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for input_binding_latch_top: drives event beats and APB writes,
// predicts the frame masks from its own copy of the binding table and compares each result.
// Depends on ibl_pkg and the input_binding_latch_top RTL.
`timescale 1ns / 1ps
module testbench;
    import ibl_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int SCAN_SETTLE  = 80;    // one full slot scan plus margin
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // code[8:0], key_repeat[9], wheel_step[11:10], pad_buttons[43:12],
    // bind_index[47:44], bind_slot[49:48], bind_oneshot[50], zero fill
    logic [55:0] s_axis_tdata = '0;
    // mode[2:0]
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // enabled_mask[15:0], oneshot_mask[31:16]
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Binding table shadow
    logic [CODE_W-1:0] bound_code [ENTRIES];
    logic [1:0]        slot_state [ENTRIES];
    logic              act_oneshot [ACTIONS];
    logic              pad_on;
    logic [31:0]       frame_masks_q [$];   // {oneshot_mask, enabled_mask}

    int          send_gap_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          frames_checked;
    int          beats_sent;
    int          idle_cycles = 0;
    logic [31:0] want_masks;

    input_binding_latch_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Move one slot latch on a press or release edge
    task automatic latch_edge(input int e, input logic press);
        if (press)
            slot_state[e] = LATCH_JUST;
        else if (slot_state[e] == LATCH_JUST)
            slot_state[e] = LATCH_ONCE;
        else
            slot_state[e] = LATCH_OFF;
    endtask

    // Update the table shadow for one accepted beat; queue masks on a frame tick
    task automatic apply_event(input t_cmd c);
        int                e;
        logic              done;
        logic              press;
        logic              hit;
        logic [CODE_W-1:0] wcode;
        logic [15:0]       en;
        logic [15:0]       os;
        done  = 1'b0;
        press = (c.mode == MODE_KEY_DOWN) || (c.mode == MODE_MOUSE_DOWN);
        en    = '0;
        os    = '0;
        case (c.mode)
            MODE_KEY_DOWN, MODE_KEY_UP: begin
                if (c.code != '0 && !(c.mode == MODE_KEY_DOWN && c.key_repeat)) begin
                    // key slot before alternate within each action
                    for (int a = 0; a < ACTIONS && !done; a++) begin
                        for (int s = int'(SLOT_KEY); s <= int'(SLOT_ALT) && !done; s++) begin
                            e = a * SLOTS + s;
                            if (bound_code[e] == c.code) begin
                                latch_edge(e, press);
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_MOUSE_DOWN, MODE_MOUSE_UP: begin
                if (c.code != '0) begin
                    for (int a = 0; a < ACTIONS && !done; a++) begin
                        e = a * SLOTS + SLOT_MOUSE;
                        if (bound_code[e] == c.code) begin
                            latch_edge(e, press);
                            done = 1'b1;
                        end
                    end
                end
            end
            MODE_WHEEL: begin
                if (c.wheel_step != 2'b00) begin
                    wcode = (c.wheel_step == 2'b01) ? WHEEL_UP_CODE : WHEEL_DOWN_CODE;
                    for (int a = 0; a < ACTIONS && !done; a++) begin
                        e = a * SLOTS + SLOT_MOUSE;
                        if (bound_code[e] == wcode) begin
                            slot_state[e] = LATCH_ONCE;
                            done = 1'b1;
                        end
                    end
                end
            end
            MODE_FRAME: begin
                // sample pad slots; codes outside the button range read as released
                if (pad_on) begin
                    for (int a = 0; a < ACTIONS; a++) begin
                        e = a * SLOTS + SLOT_PAD;
                        if (bound_code[e] != '0 && bound_code[e] < PAD_BUTTONS &&
                            c.pad_buttons[bound_code[e][4:0]])
                            slot_state[e] = (slot_state[e] == LATCH_OFF) ? LATCH_JUST
                                                                         : LATCH_HELD;
                        else
                            slot_state[e] = LATCH_OFF;
                    end
                end
                // build masks
                for (int a = 0; a < ACTIONS; a++) begin
                    hit = 1'b0;
                    for (int s = 0; s < SLOTS; s++) begin
                        e = a * SLOTS + s;
                        if (act_oneshot[a]) begin
                            if (slot_state[e] == LATCH_JUST || slot_state[e] == LATCH_ONCE)
                                hit = 1'b1;
                        end else if (slot_state[e] != LATCH_OFF) begin
                            hit = 1'b1;
                        end
                    end
                    en[a] = hit;
                    os[a] = hit && act_oneshot[a];
                end
                // age every latch
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_state[i] == LATCH_ONCE)
                        slot_state[i] = LATCH_OFF;
                    else if (slot_state[i] == LATCH_JUST)
                        slot_state[i] = LATCH_HELD;
                end
                frame_masks_q.insert(frame_masks_q.size(), {os, en});
            end
            MODE_BIND: begin
                if (int'(c.bind_index) < ACTIONS) begin
                    e = int'(c.bind_index) * SLOTS + int'(c.bind_slot);
                    bound_code[e]             = c.code;
                    slot_state[e]             = LATCH_OFF;
                    act_oneshot[c.bind_index] = c.bind_oneshot;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Present one beat, hold it until accepted; entered and left at a falling edge
    task automatic send_beat(input t_cmd c);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.bind_oneshot, c.bind_slot, c.bind_index,
                          c.pad_buttons, c.wheel_step, c.key_repeat, c.code};
        s_axis_tuser  <= c.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_event(c);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every queued result, then let a scan finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_masks_q.size() != 0)
            @(negedge i_clk);
        repeat (SCAN_SETTLE) @(negedge i_clk);
    endtask

    // APB write: setup then access, only with the engine idle
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_PAD_PRESENT)
            pad_on = value[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_cmd cmd_of(input logic [2:0] mode, input logic [CODE_W-1:0] code);
        t_cmd c;
        c      = '0;
        c.mode = mode;
        c.code = code;
        return c;
    endfunction

    task automatic bind_entry(input int idx, input logic [1:0] slot,
                              input logic [CODE_W-1:0] code, input logic oneshot);
        t_cmd c;
        c              = cmd_of(MODE_BIND, code);
        c.bind_index   = 4'(idx);
        c.bind_slot    = slot;
        c.bind_oneshot = oneshot;
        send_beat(c);
    endtask

    task automatic send_wheel(input logic [1:0] step);
        t_cmd c;
        c            = cmd_of(MODE_WHEEL, '0);
        c.wheel_step = step;
        send_beat(c);
    endtask

    task automatic send_frame(input logic [31:0] buttons);
        t_cmd c;
        c             = cmd_of(MODE_FRAME, '0);
        c.pad_buttons = buttons;
        send_beat(c);
    endtask

    // Random beat: small code pool so events hit bound slots
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        c.pad_buttons  = $urandom;
        c.key_repeat   = ($urandom_range(3) == 0);
        c.wheel_step   = 2'($urandom_range(3));
        c.bind_index   = 4'($urandom_range(15));
        c.bind_slot    = 2'($urandom_range(3));
        c.bind_oneshot = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 75)
            c.code = 9'($urandom_range(12, 1));
        else if (pick < 85)
            c.code = $urandom_range(1) ? WHEEL_UP_CODE : WHEEL_DOWN_CODE;
        else
            c.code = 9'($urandom_range(511));
        pick = $urandom_range(99);
        if (pick < 10)      c.mode = MODE_BIND;
        else if (pick < 32) c.mode = MODE_KEY_DOWN;
        else if (pick < 52) c.mode = MODE_KEY_UP;
        else if (pick < 62) c.mode = MODE_MOUSE_DOWN;
        else if (pick < 72) c.mode = MODE_MOUSE_UP;
        else if (pick < 80) c.mode = MODE_WHEEL;
        else if (pick < 97) c.mode = MODE_FRAME;
        else                c.mode = MODE_UNUSED;
        return c;
    endfunction

    // Bindings, first-match order, key repeat, code zero, wheel directions, unused mode
    task automatic test_bindings_and_events();
        t_cmd c;
        bind_entry(0, SLOT_KEY, 9'd1, 1'b0);
        bind_entry(0, SLOT_ALT, 9'h1FF, 1'b0);
        bind_entry(1, SLOT_KEY, 9'd1, 1'b1);            // shadowed by action 0
        bind_entry(2, SLOT_MOUSE, 9'd3, 1'b0);
        bind_entry(14, SLOT_MOUSE, WHEEL_DOWN_CODE, 1'b1);
        bind_entry(15, SLOT_MOUSE, WHEEL_UP_CODE, 1'b1);
        c = cmd_of(MODE_KEY_DOWN, 9'd1);
        c.key_repeat = 1'b1;
        send_beat(c);
        send_beat(cmd_of(MODE_KEY_DOWN, 9'd0));
        send_frame('0);
        send_beat(cmd_of(MODE_KEY_DOWN, 9'd1));
        send_beat(cmd_of(MODE_KEY_DOWN, 9'h1FF));
        send_beat(cmd_of(MODE_MOUSE_DOWN, 9'd3));
        send_wheel(2'b01);
        send_wheel(2'b11);
        send_wheel(2'b00);
        send_frame('0);
        send_beat(cmd_of(MODE_KEY_UP, 9'd1));
        send_wheel(2'b10);
        send_beat(cmd_of(MODE_MOUSE_UP, 9'd3));
        send_frame('0);
        // press and release inside one frame leaves a one-frame pulse
        send_beat(cmd_of(MODE_KEY_DOWN, 9'd1));
        send_beat(cmd_of(MODE_KEY_UP, 9'd1));
        send_beat(cmd_of(MODE_UNUSED, 9'd1));
        send_frame('0);
        send_frame('0);
    endtask

    // Pad slots: sampled only when attached, out-of-range codes never pressed
    task automatic test_pad_sampling();
        bind_entry(3, SLOT_PAD, 9'd31, 1'b0);
        bind_entry(4, SLOT_PAD, 9'd32, 1'b1);
        bind_entry(15, SLOT_PAD, 9'd1, 1'b1);
        send_frame('1);
        write_reg(REG_PAD_PRESENT, 32'd1);
        send_frame('1);
        send_frame('1);
        send_frame(32'h8000_0002);
        send_frame('0);
        write_reg(REG_PAD_PRESENT, 32'd0);
        send_frame('1);
    endtask

    // Random traffic at one pad setting; pause once for a full drain midway
    task automatic test_random_traffic(input logic pad, input int count);
        t_cmd c;
        int   done_cnt;
        logic ignored;
        done_cnt = 0;
        write_reg(REG_PAD_PRESENT, {31'd0, pad});
        while (done_cnt < count) begin
            c = random_cmd();
            send_beat(c);
            ignored = (c.mode == MODE_UNUSED) ||
                      (c.mode == MODE_WHEEL && c.wheel_step == 2'b00) ||
                      (c.mode == MODE_KEY_DOWN && c.key_repeat) ||
                      ((c.mode inside {MODE_KEY_DOWN, MODE_KEY_UP, MODE_MOUSE_DOWN,
                                       MODE_MOUSE_UP}) && c.code == '0);
            if (!ignored)
                done_cnt++;
            if (done_cnt == count / 2 && !ignored)
                wait_idle();
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            bound_code[i] = '0;
            slot_state[i] = LATCH_OFF;
        end
        for (int a = 0; a < ACTIONS; a++)
            act_oneshot[a] = 1'b0;
        pad_on         = 1'b0;
        mismatches     = 0;
        frames_checked = 0;
        beats_sent     = 0;
        send_gap_pct   = 21;
        recv_stall_pct = 59;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_bindings_and_events();
        test_pad_sampling();
        for (int ph = 0; ph < 3; ph++) begin
            send_gap_pct   = (ph == 0) ? 21 : (ph == 1) ? 59 : 0;
            recv_stall_pct = (ph == 0) ? 59 : (ph == 1) ? 21 : 0;
            test_random_traffic(1'b1, 330);
            test_random_traffic(1'b0, 330);
        end
        wait_idle();

        $display("Sent %0d event beats and checked %0d frame results, pad attached and detached",
                 beats_sent, frames_checked);
        $display("under three sender/receiver idle mixes; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver stalls at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest predicted masks
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_masks_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result beat %h", $realtime, m_axis_tdata);
            end else begin
                want_masks = frame_masks_q.pop_front();
                frames_checked++;
                if (m_axis_tdata[15:0] !== want_masks[15:0] ||
                    m_axis_tdata[31:16] !== want_masks[31:16]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] frame %0d: enabled exp %h got %h, oneshot exp %h got %h",
                                 $realtime, frames_checked, want_masks[15:0],
                                 m_axis_tdata[15:0], want_masks[31:16], m_axis_tdata[31:16]);
                end
            end
        end
    end

    // End the run when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ibl_pkg.sv
design/ibl_engine.sv
design/input_binding_latch_top.sv
bench/testbench.sv
